@@ sv/ppi_pkg.sv @@
`timescale 1ns / 1ps
package ppi_pkg;

  localparam int ANGLE_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] INV_TWO_PI  = 32'sd683565276;

  localparam logic [1:0] OP_SET_VEL = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESET   = 2'd2;

  // datapath commands
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LOAD_VEL  = 4'd1;
  localparam logic [3:0] CMD_TICK_INIT = 4'd2;
  localparam logic [3:0] CMD_ROT       = 4'd3;
  localparam logic [3:0] CMD_MUL_V     = 4'd4;
  localparam logic [3:0] CMD_VEL_SUM   = 4'd5;
  localparam logic [3:0] CMD_STEP_MUL  = 4'd6;
  localparam logic [3:0] CMD_POS_UPD   = 4'd7;
  localparam logic [3:0] CMD_QUAT_INIT = 4'd8;
  localparam logic [3:0] CMD_QUAT_OUT  = 4'd9;
  localparam logic [3:0] CMD_RST_INIT  = 4'd10;
  localparam logic [3:0] CMD_RST_PRE   = 4'd11;
  localparam logic [3:0] CMD_VEC       = 4'd12;
  localparam logic [3:0] CMD_RST_DONE  = 4'd13;

  localparam logic [1:0] MODE_ROTATE = 2'd0;
  localparam logic [1:0] MODE_VECTOR = 2'd1;

  typedef struct packed {
    logic [3:0] cmd;
    logic [4:0] iter;
  } ppi_cmd_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/ppi_ctrl.sv @@
`timescale 1ns / 1ps
module ppi_ctrl #(
  parameter int CORDIC_STAGES = ppi_pkg::CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  output logic             out_valid,
  input  logic             out_stall,
  output ppi_pkg::ppi_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROT   = 4'd1;
  localparam logic [3:0] S_MULV  = 4'd2;
  localparam logic [3:0] S_VSUM  = 4'd3;
  localparam logic [3:0] S_SMUL  = 4'd4;
  localparam logic [3:0] S_POS   = 4'd5;
  localparam logic [3:0] S_QINIT = 4'd6;
  localparam logic [3:0] S_QROT  = 4'd7;
  localparam logic [3:0] S_QOUT  = 4'd8;
  localparam logic [3:0] S_RPRE  = 4'd9;
  localparam logic [3:0] S_VEC   = 4'd10;
  localparam logic [3:0] S_RDONE = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [4:0] LAST    = 5'(CORDIC_STAGES - 1);

  logic [3:0] state_r, state_nxt;
  logic [4:0] iter_r, iter_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.cmd       = ppi_pkg::CMD_NONE;
    cmd.iter      = iter_r;
    case (state_r)
      S_IDLE: begin
        iter_nxt = '0;
        if (take) begin
          case (in_op)
            ppi_pkg::OP_SET_VEL: cmd.cmd = ppi_pkg::CMD_LOAD_VEL;
            ppi_pkg::OP_TICK: begin
              cmd.cmd   = ppi_pkg::CMD_TICK_INIT;
              state_nxt = S_ROT;
            end
            ppi_pkg::OP_RESET: begin
              cmd.cmd   = ppi_pkg::CMD_RST_INIT;
              state_nxt = S_RPRE;
            end
            default: cmd.cmd = ppi_pkg::CMD_NONE;
          endcase
        end
      end
      S_ROT: begin
        cmd.cmd  = ppi_pkg::CMD_ROT;
        iter_nxt = iter_r + 5'd1;
        if (iter_r == LAST) state_nxt = S_MULV;
      end
      S_MULV: begin
        cmd.cmd = ppi_pkg::CMD_MUL_V;
        state_nxt = S_VSUM;
      end
      S_VSUM: begin
        cmd.cmd = ppi_pkg::CMD_VEL_SUM;
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        cmd.cmd = ppi_pkg::CMD_STEP_MUL;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.cmd = ppi_pkg::CMD_POS_UPD;
        state_nxt = S_QINIT;
      end
      S_QINIT: begin
        cmd.cmd   = ppi_pkg::CMD_QUAT_INIT;
        iter_nxt  = '0;
        state_nxt = S_QROT;
      end
      S_QROT: begin
        cmd.cmd  = ppi_pkg::CMD_ROT;
        iter_nxt = iter_r + 5'd1;
        if (iter_r == LAST) state_nxt = S_QOUT;
      end
      S_QOUT: begin
        cmd.cmd = ppi_pkg::CMD_QUAT_OUT;
        state_nxt = S_OUT;
      end
      S_RPRE: begin
        cmd.cmd   = ppi_pkg::CMD_RST_PRE;
        iter_nxt  = '0;
        state_nxt = S_VEC;
      end
      S_VEC: begin
        cmd.cmd  = ppi_pkg::CMD_VEC;
        iter_nxt = iter_r + 5'd1;
        if (iter_r == LAST) state_nxt = S_RDONE;
      end
      S_RDONE: begin
        cmd.cmd = ppi_pkg::CMD_RST_DONE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/ppi_datapath.sv @@
`timescale 1ns / 1ps
module ppi_datapath #(
  parameter int ANGLE_BITS = ppi_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppi_pkg::ppi_cmd_t   cmd,
  input  logic signed [31:0]  in_vel_fwd,
  input  logic signed [31:0]  in_vel_side,
  input  logic signed [31:0]  in_yaw_rate,
  input  logic [15:0]         in_time_step,
  input  logic signed [31:0]  in_set_x,
  input  logic signed [31:0]  in_set_y,
  input  logic signed [15:0]  in_set_qx,
  input  logic signed [15:0]  in_set_qy,
  input  logic signed [15:0]  in_set_qz,
  input  logic signed [15:0]  in_set_qw,
  output logic signed [31:0]  out_pose_x,
  output logic signed [31:0]  out_pose_y,
  output logic signed [15:0]  out_orient_x,
  output logic signed [15:0]  out_orient_y,
  output logic signed [15:0]  out_orient_z,
  output logic signed [15:0]  out_orient_w,
  output logic                out_accepted
);

  localparam int AB = ANGLE_BITS;
  localparam int SH = 32 - ANGLE_BITS;

  // state
  logic signed [31:0] pos_x_r, pos_y_r, fwd_r, side_r, yaw_r;
  logic [AB-1:0]      heading_r;
  // work registers
  logic [15:0]        dt_r;
  logic [1:0]         quad_r;
  logic signed [55:0] cx_r, cy_r;   // rotation mode fits in 34, vectoring needs 56
  logic signed [33:0] cz_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [47:0] vx_r, vy_r;
  logic signed [63:0] tr_r;
  logic               zero_head_r;
  logic [31:0]        vz_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;

  logic signed [33:0] cs, sn;
  logic [31:0]        ang;
  logic signed [55:0] shx, shy;
  logic signed [33:0] at;

  function automatic logic [1:0] quad_of(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h20000000;
    return t[31:30];
  endfunction

  function automatic logic signed [15:0] qout(input logic signed [33:0] v);
    logic signed [34:0] r;
    logic signed [18:0] q;
    r = 35'(v) + 35'sd32768;
    q = 19'(r >>> 16);
    if (q > 19'sd16384) q = 19'sd16384;
    if (q < -19'sd16384) q = -19'sd16384;
    return q[15:0];
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign shx = cx_r >>> cmd.iter;
  assign shy = cy_r >>> cmd.iter;
  assign at  = 34'(ppi_pkg::atan_entry(cmd.iter));

  always_comb begin
    case (quad_r)
      2'd0: begin cs = cx_r[33:0];  sn = cy_r[33:0];  end
      2'd1: begin cs = -cy_r[33:0]; sn = cx_r[33:0];  end
      2'd2: begin cs = -cx_r[33:0]; sn = -cy_r[33:0]; end
      default: begin cs = cy_r[33:0]; sn = -cx_r[33:0]; end
    endcase
  end

  always_comb begin
    ang = 32'(heading_r) << SH;
  end

  logic signed [63:0] qsq_w, qsq_x, qsq_y, qsq_z, nrm, m20, ay, ax;
  always_comb begin
    qsq_w = 64'(qw_r) * 64'(qw_r);
    qsq_x = 64'(qx_r) * 64'(qx_r);
    qsq_y = 64'(qy_r) * 64'(qy_r);
    qsq_z = 64'(qz_r) * 64'(qz_r);
    nrm   = qsq_w + qsq_x + qsq_y + qsq_z;
    m20   = 2 * (64'(qx_r) * 64'(qz_r) - 64'(qw_r) * 64'(qy_r));
    if (m20 < 0) m20 = -m20;
    ay    = 2 * (64'(qw_r) * 64'(qz_r) + 64'(qx_r) * 64'(qy_r));
    ax    = qsq_w + qsq_x - qsq_y - qsq_z;
  end

  logic [31:0] angq, hq;
  logic [32:0] vzr;
  always_comb begin
    angq = ang - {quad_of(ang), 30'd0};
    hq   = ang >> 1;
    vzr  = {1'b0, vz_r} + ((SH > 0) ? (33'd1 << (SH > 0 ? SH - 1 : 0)) : 33'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0; pos_y_r <= '0; heading_r <= '0;
      fwd_r <= '0; side_r <= '0; yaw_r <= '0;
      out_accepted <= 1'b0;
    end else begin
      case (cmd.cmd)
        ppi_pkg::CMD_LOAD_VEL: begin
          fwd_r <= in_vel_fwd; side_r <= in_vel_side; yaw_r <= in_yaw_rate;
        end
        ppi_pkg::CMD_TICK_INIT: begin
          dt_r   <= in_time_step;
          quad_r <= quad_of(ang);
          cz_r   <= 34'(signed'(angq));
          cx_r   <= 56'(ppi_pkg::CORDIC_GAIN);
          cy_r   <= '0;
          tr_r   <= 64'(yaw_r) * 64'(ppi_pkg::INV_TWO_PI);
        end
        ppi_pkg::CMD_ROT: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - shy; cy_r <= cy_r + shx; cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + shy; cy_r <= cy_r - shx; cz_r <= cz_r + at;
          end
        end
        ppi_pkg::CMD_MUL_V: begin
          p0_r <= 64'(fwd_r) * 64'(cs);
          p1_r <= 64'(side_r) * 64'(sn);
          p2_r <= 64'(fwd_r) * 64'(sn);
          p3_r <= 64'(side_r) * 64'(cs);
          tr_r <= (tr_r + 64'sd32768) >>> 16;
        end
        ppi_pkg::CMD_VEL_SUM: begin
          vx_r <= 48'((p0_r - p1_r + (64'sd1 <<< 29)) >>> 30);
          vy_r <= 48'((p2_r + p3_r + (64'sd1 <<< 29)) >>> 30);
          tr_r <= tr_r * 64'(signed'({1'b0, dt_r}));
        end
        ppi_pkg::CMD_STEP_MUL: begin
          p0_r <= 64'(vx_r) * 64'(signed'({1'b0, dt_r}));
          p1_r <= 64'(vy_r) * 64'(signed'({1'b0, dt_r}));
          tr_r <= (tr_r + (64'sd1 <<< (47 - AB))) >>> (48 - AB);
        end
        ppi_pkg::CMD_POS_UPD: begin
          pos_x_r   <= sat(64'(pos_x_r) + ((p0_r + 64'sd32768) >>> 16));
          pos_y_r   <= sat(64'(pos_y_r) + ((p1_r + 64'sd32768) >>> 16));
          heading_r <= heading_r + tr_r[AB-1:0];
        end
        ppi_pkg::CMD_QUAT_INIT: begin
          quad_r <= quad_of(hq);
          cz_r   <= 34'(signed'(hq - {quad_of(hq), 30'd0}));
          cx_r   <= 56'(ppi_pkg::CORDIC_GAIN);
          cy_r   <= '0;
        end
        ppi_pkg::CMD_QUAT_OUT: begin
          out_pose_x   <= pos_x_r;
          out_pose_y   <= pos_y_r;
          out_orient_x <= '0;
          out_orient_y <= '0;
          out_orient_z <= qout(sn);
          out_orient_w <= qout(cs);
          out_accepted <= 1'b0;
        end
        ppi_pkg::CMD_RST_INIT: begin
          pos_x_r <= in_set_x; pos_y_r <= in_set_y;
          qx_r <= in_set_qx; qy_r <= in_set_qy; qz_r <= in_set_qz; qw_r <= in_set_qw;
        end
        ppi_pkg::CMD_RST_PRE: begin
          zero_head_r <= (m20 >= nrm) || (ax == 0 && ay == 0);
          if (ax < 0) begin
            cx_r <= 56'(-ax) <<< 20; cy_r <= 56'(-ay) <<< 20; vz_r <= 32'h80000000;
          end else begin
            cx_r <= 56'(ax) <<< 20;  cy_r <= 56'(ay) <<< 20;  vz_r <= '0;
          end
        end
        ppi_pkg::CMD_VEC: begin
          if (!cy_r[55]) begin
            cx_r <= cx_r + shy; cy_r <= cy_r - shx; vz_r <= vz_r + at[31:0];
          end else begin
            cx_r <= cx_r - shy; cy_r <= cy_r + shx; vz_r <= vz_r - at[31:0];
          end
        end
        ppi_pkg::CMD_RST_DONE: begin
          heading_r    <= zero_head_r ? '0 : AB'(vzr >> SH);
          out_pose_x   <= pos_x_r;
          out_pose_y   <= pos_y_r;
          out_orient_x <= qx_r;
          out_orient_y <= qy_r;
          out_orient_z <= qz_r;
          out_orient_w <= qw_r;
          out_accepted <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sv/planar_pose_integrator.sv @@
`timescale 1ns / 1ps
// Planar dead-reckoning pose integrator.
// Input channel (in_valid / in_stall) carries one beat per command: op 0
// stores body velocities and yields no result, op 1 integrates one time
// step, op 2 loads a pose from position and quaternion, op 3 is dropped.
// Output channel (out_valid / out_stall) carries one beat per tick or
// reset: the pose, the yaw or loaded quaternion and the accepted flag.
// A tick runs two passes of one shared iterative CORDIC plus multiply and
// accumulate steps; a reset runs one vectoring CORDIC pass. A set velocity
// beat is stored as it is taken. One item is worked on at a time.
// The result sits in an output register; in_stall stays high while the
// block is busy or a result waits, so a stalled receiver holds the beat
// and the block takes no new work until it drains.
// Synchronous reset (rst_n low) clears pose, heading and stored
// velocities to zero and empties the output register.
module planar_pose_integrator #(
  parameter int ANGLE_BITS    = ppi_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = ppi_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_vel_fwd,
  input  logic signed [31:0] in_vel_side,
  input  logic signed [31:0] in_yaw_rate,
  input  logic [15:0]        in_time_step,
  input  logic signed [31:0] in_set_x,
  input  logic signed [31:0] in_set_y,
  input  logic signed [15:0] in_set_qx,
  input  logic signed [15:0] in_set_qy,
  input  logic signed [15:0] in_set_qz,
  input  logic signed [15:0] in_set_qw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [15:0] out_orient_x,
  output logic signed [15:0] out_orient_y,
  output logic signed [15:0] out_orient_z,
  output logic signed [15:0] out_orient_w,
  output logic               out_accepted
);

  ppi_pkg::ppi_cmd_t cmd;

  ppi_ctrl #(.CORDIC_STAGES(CORDIC_STAGES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .out_valid, .out_stall, .cmd
  );

  ppi_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .in_vel_fwd, .in_vel_side, .in_yaw_rate, .in_time_step,
    .in_set_x, .in_set_y, .in_set_qx, .in_set_qy, .in_set_qz, .in_set_qw,
    .out_pose_x, .out_pose_y, .out_orient_x, .out_orient_y,
    .out_orient_z, .out_orient_w, .out_accepted
  );

endmodule

@@ sim/planar_pose_integrator_tb.sv @@
`timescale 1ns / 1ps
module planar_pose_integrator_tb;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] fwd, side, yaw;
    logic [15:0]        dt;
    logic signed [31:0] sx, sy;
    logic signed [15:0] qx, qy, qz, qw;
  } cmd_t;

  typedef struct {
    logic signed [31:0] x, y;
    logic signed [15:0] qx, qy, qz, qw;
    logic               acc;
  } pose_t;

  typedef struct {
    cmd_t  c;
    bit    has_exp;
    pose_t e;
  } row_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [31:0] ARC_TAB [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };
  localparam longint TURN_PER_RAD = 64'sd683565276;
  localparam longint UNIT_GAIN    = 64'sd652032874;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_op;
  logic signed [31:0] in_vel_fwd, in_vel_side, in_yaw_rate, in_set_x, in_set_y;
  logic [15:0] in_time_step;
  logic signed [15:0] in_set_qx, in_set_qy, in_set_qz, in_set_qw;
  logic out_valid, out_stall, out_accepted;
  logic signed [31:0] out_pose_x, out_pose_y;
  logic signed [15:0] out_orient_x, out_orient_y, out_orient_z, out_orient_w;

  planar_pose_integrator u_top (.*);

  longint      pose_x_m, pose_y_m, fwd_m, side_m, yaw_m;
  logic [31:0] hdg_m;
  pose_t       pose_q[$];
  int          errors, ticks_seen, resets_seen, phase;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint rnd_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [15:0] quat_q14(longint v);
    longint r;
    r = rnd_sh(v, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic void sin_cos(input logic [31:0] a, output longint cs,
                                  output longint sn);
    logic [31:0] q, r;
    longint x, y, z, t;
    q = ((a + 32'h20000000) >> 30) & 32'd3;
    r = a - (q << 30);
    z = longint'($signed(r));
    x = UNIT_GAIN;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - longint'(ARC_TAB[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + longint'(ARC_TAB[i]);
      end
    end
    case (q)
      0: begin cs = x;  sn = y;  end
      1: begin cs = -y; sn = x;  end
      2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic logic [31:0] yaw_angle(longint y, longint x);
    logic [31:0] z;
    longint t;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    x = x <<< 20;
    y = y <<< 20;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + ARC_TAB[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - ARC_TAB[i];
      end
    end
    return z;
  endfunction

  // advance the pose state by one beat; returns 1 when a result follows
  function automatic bit integrate(input cmd_t c, output pose_t p);
    longint cs, sn, vx, vy, tr, d, dt, qx, qy, qz, qw, nrm, m20, ay, ax;
    p = '{default: 0};
    case (c.op)
      ppi_pkg::OP_SET_VEL: begin
        fwd_m = c.fwd; side_m = c.side; yaw_m = c.yaw;
        return 0;
      end
      ppi_pkg::OP_TICK: begin
        dt = longint'(c.dt);
        sin_cos(hdg_m, cs, sn);
        vx = rnd_sh(fwd_m * cs - side_m * sn, 30);
        vy = rnd_sh(fwd_m * sn + side_m * cs, 30);
        pose_x_m = sat32(pose_x_m + rnd_sh(vx * dt, 16));
        pose_y_m = sat32(pose_y_m + rnd_sh(vy * dt, 16));
        tr = rnd_sh(yaw_m * TURN_PER_RAD, 16);
        d = rnd_sh(tr * dt, 16);
        hdg_m = hdg_m + d[31:0];
        sin_cos(hdg_m >> 1, cs, sn);
        p.x = pose_x_m[31:0]; p.y = pose_y_m[31:0];
        p.qz = quat_q14(sn); p.qw = quat_q14(cs);
        return 1;
      end
      ppi_pkg::OP_RESET: begin
        qx = c.qx; qy = c.qy; qz = c.qz; qw = c.qw;
        nrm = qw * qw + qx * qx + qy * qy + qz * qz;
        m20 = 2 * (qx * qz - qw * qy);
        ay = 2 * (qw * qz + qx * qy);
        ax = qw * qw + qx * qx - qy * qy - qz * qz;
        if (m20 < 0) m20 = -m20;
        pose_x_m = c.sx; pose_y_m = c.sy;
        if (m20 >= nrm || (ax == 0 && ay == 0)) hdg_m = 0;
        else hdg_m = yaw_angle(ay, ax);
        p = '{x: c.sx, y: c.sy, qx: c.qx, qy: c.qy, qz: c.qz, qw: c.qw, acc: 1'b1};
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic cmd_t noise_cmd(logic [1:0] op);
    cmd_t c;
    c = '{op: op, fwd: $urandom, side: $urandom, yaw: $urandom, dt: 16'($urandom),
          sx: $urandom, sy: $urandom, qx: 16'($urandom), qy: 16'($urandom),
          qz: 16'($urandom), qw: 16'($urandom)};
    return c;
  endfunction

  function automatic row_t vel_row(logic signed [31:0] f, s, y);
    row_t r;
    r.c = noise_cmd(ppi_pkg::OP_SET_VEL);
    r.c.fwd = f; r.c.side = s; r.c.yaw = y;
    r.has_exp = 0;
    r.e = '{default: 0};
    return r;
  endfunction

  function automatic row_t tick_row(logic [15:0] dt);
    row_t r;
    r.c = noise_cmd(ppi_pkg::OP_TICK);
    r.c.dt = dt;
    r.has_exp = 0;
    r.e = '{default: 0};
    return r;
  endfunction

  function automatic row_t rst_row(logic signed [31:0] x, y,
                                   logic signed [15:0] qx, qy, qz, qw);
    row_t r;
    r.c = noise_cmd(ppi_pkg::OP_RESET);
    r.c.sx = x; r.c.sy = y; r.c.qx = qx; r.c.qy = qy; r.c.qz = qz; r.c.qw = qw;
    r.has_exp = 1;
    r.e = '{x: x, y: y, qx: qx, qy: qy, qz: qz, qw: qw, acc: 1'b1};
    return r;
  endfunction

  function automatic logic signed [15:0] rand_q();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'h7FFFFFFF ^ {32{$urandom_range(0, 1) == 1}};
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, exp);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
  endtask

  task automatic send(input cmd_t c, input bit has_exp, input pose_t e);
    pose_t p;
    in_valid <= 1; in_op <= c.op;
    in_vel_fwd <= c.fwd; in_vel_side <= c.side; in_yaw_rate <= c.yaw;
    in_time_step <= c.dt; in_set_x <= c.sx; in_set_y <= c.sy;
    in_set_qx <= c.qx; in_set_qy <= c.qy; in_set_qz <= c.qz; in_set_qw <= c.qw;
    do @(posedge clk); while (in_stall);
    if (integrate(c, p)) pose_q.push_back(has_exp ? e : p);
    if (phase < 2 && $urandom_range(0, 99) < (phase == 0 ? 10 : 76)) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (phase == 0) out_stall <= $urandom_range(0, 99) < 76;
    else if (phase == 1) out_stall <= $urandom_range(0, 99) < 10;
    else out_stall <= 0;
  end

  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        e = pose_q.pop_front();
        if (e.acc) resets_seen++;
        else ticks_seen++;
        if (out_pose_x !== e.x) report("pose_x", out_pose_x, e.x);
        if (out_pose_y !== e.y) report("pose_y", out_pose_y, e.y);
        if (out_orient_x !== e.qx) report("orient_x", 32'(out_orient_x), 32'(e.qx));
        if (out_orient_y !== e.qy) report("orient_y", 32'(out_orient_y), 32'(e.qy));
        if (out_orient_z !== e.qz) report("orient_z", 32'(out_orient_z), 32'(e.qz));
        if (out_orient_w !== e.qw) report("orient_w", 32'(out_orient_w), 32'(e.qw));
        if (out_accepted !== e.acc) report("accepted", 32'(out_accepted), 32'(e.acc));
      end
    end
  end

  initial begin
    row_t  dir_tab[$];
    row_t  r;
    pose_t none;
    int    n_ticks, k;
    none = '{default: 0};
    errors = 0; ticks_seen = 0; resets_seen = 0; phase = 0;
    rst_n = 0; in_valid = 0; in_op = ppi_pkg::OP_SET_VEL;
    in_vel_fwd = 0; in_vel_side = 0; in_yaw_rate = 0; in_time_step = 0;
    in_set_x = 0; in_set_y = 0; in_set_qx = 0; in_set_qy = 0; in_set_qz = 0; in_set_qw = 0;
    fwd_m = 0; side_m = 0; yaw_m = 0; pose_x_m = 0; pose_y_m = 0; hdg_m = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    dir_tab.push_back(tick_row(16'h0000));
    dir_tab.push_back(vel_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    dir_tab.push_back(tick_row(16'hFFFF));
    dir_tab.push_back(tick_row(16'hFFFF));
    dir_tab.push_back(vel_row(32'h80000000, 32'h80000000, 32'h80000000));
    dir_tab.push_back(tick_row(16'hFFFF));
    dir_tab.push_back(tick_row(16'h0000));
    dir_tab.push_back(rst_row(32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 16384));
    dir_tab.push_back(vel_row(32'h00010000, 0, 32'h0001921F));
    dir_tab.push_back(tick_row(16'h8000));
    dir_tab.push_back(rst_row(32'h00050000, -32'sh00030000, 0, 0, 11585, 11585));
    dir_tab.push_back(tick_row(16'h4000));
    dir_tab.push_back(rst_row(0, 0, 0, 11585, 0, 11585));
    dir_tab.push_back(tick_row(16'h0147));
    dir_tab.push_back(rst_row(1, -1, 0, 0, 0, 0));
    dir_tab.push_back(rst_row(0, 0, 4096, 4096, -4096, 4096));
    dir_tab.push_back(rst_row(32'h80000000, 32'h7FFFFFFF, -16384, 16384, -16384, 16384));
    dir_tab.push_back(rst_row(0, 0, 0, 0, 16384, 0));
    dir_tab.push_back(rst_row(0, 0, 0, 0, -16384, -16384));
    r = tick_row(0);
    r.c.op = OP_UNUSED;
    dir_tab.push_back(r);
    dir_tab.push_back(tick_row(16'hFFFF));
    dir_tab.push_back(vel_row(0, 32'h00020000, -32'sh00008000));
    dir_tab.push_back(tick_row(16'h1234));
    foreach (dir_tab[i]) send(dir_tab[i].c, dir_tab[i].has_exp, dir_tab[i].e);

    k = 0;
    while (k < 450) begin
      phase = k / 150;
      if ($urandom_range(0, 9) == 0) begin
        r = rst_row($urandom, $urandom, rand_q(), rand_q(), rand_q(), rand_q());
        if ($urandom_range(0, 1)) begin
          r.c.qx = 0; r.c.qy = 0;
        end
        send(r.c, 0, none);
        k++;
      end else if ($urandom_range(0, 19) == 0) begin
        send(noise_cmd(OP_UNUSED), 0, none);
      end else begin
        r = vel_row(rand_vel(), rand_vel(), rand_vel());
        send(r.c, 0, none);
        n_ticks = $urandom_range(1, 6);
        for (int j = 0; j < n_ticks; j++) begin
          r = tick_row($urandom_range(0, 3) == 0 ? 16'($urandom)
                                                 : 16'($urandom_range(0, 2700)));
          send(r.c, 0, none);
        end
        k += n_ticks + 1;
      end
    end
    in_valid <= 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d tick results and %0d pose loads, with sender and receiver idling",
             ticks_seen, resets_seen);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ppi_pkg.sv
sv/ppi_ctrl.sv
sv/ppi_datapath.sv
sv/planar_pose_integrator.sv
sim/planar_pose_integrator_tb.sv
